### rtl/core/fhte_pkg.sv
// Shared types, codes and a helper function for the fixed-Huffman token encoder.
// No dependencies; imported by every module of the encoder.
package fhte_pkg;

    // Token kinds
    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_LITERAL = 2'd1,
        OP_MATCH   = 2'd2,
        OP_EOB     = 2'd3
    } t_opcode;

    // Input word
    typedef struct packed {
        t_opcode     opcode;
        logic        final_block;
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } t_token;

    // Result word
    typedef struct packed {
        logic [30:0] code_bits;
        logic [4:0]  bit_count;
    } t_result;

    // Literal/length code in wire order (first bit in bit 0) with its length
    typedef struct packed {
        logic [8:0] bits;
        logic [3:0] len;
    } t_code;

    // Length symbol, as handed from the length mapper to the top level
    typedef struct packed {
        t_code      code;
        logic [4:0] extra_val;
        logic [2:0] extra_cnt;
    } t_len_sym;

    // Distance symbol, as handed from the distance mapper to the top level
    typedef struct packed {
        logic [4:0]  bits;
        logic [12:0] extra_val;
        logic [3:0]  extra_cnt;
    } t_dist_sym;

    localparam logic [8:0] SYM_EOB       = 9'd256;
    localparam logic [8:0] SYM_LEN_FIRST = 9'd257;
    localparam logic [3:0] HDR_BITS      = 4'd3;

    // Fixed literal/length code for one symbol, bit-reversed so that the
    // most significant code bit goes first on the wire.
    function automatic t_code litlen_wire(input logic [8:0] sym);
        logic [8:0] code;
        logic [8:0] aligned;
        t_code      res;
        if (sym <= 9'd143) begin
            code    = 9'h030 + sym;
            res.len = 4'd8;
        end else if (sym <= 9'd255) begin
            code    = 9'h190 + (sym - 9'd144);
            res.len = 4'd9;
        end else if (sym <= 9'd279) begin
            code    = sym - 9'd256;
            res.len = 4'd7;
        end else begin
            code    = 9'h0C0 + {6'd0, sym[2:0] - 3'd0};
            res.len = 4'd8;
        end
        // Left-align into nine bits, then reverse
        aligned = code << (4'd9 - res.len);
        for (int i = 0; i < 9; i++) begin
            res.bits[i] = aligned[8 - i];
        end
        return res;
    endfunction

endpackage

### rtl/core/deflate_fixed_huffman_token_encoder_unit.sv
// Top level of the DEFLATE fixed-Huffman token encoder.
// Depends on fhte_pkg, fhte_len_map and fhte_dist_map.
//
// Usage:
//   Input channel: drive a token word on i_token and raise start; the word is
//   taken at every rising edge where start is high and busy is low. busy is
//   held low, so a token may be offered in every cycle.
//   Output channel: each token yields one result word on o_result, marked by
//   o_strobe for exactly one cycle. The receiver has no way to hold it off.
//   code_bits carries the bit string with the first bit to send in bit 0;
//   bits at and above bit_count are zero.
//   Path: a token is captured in the input register, then passes one stage of
//   table lookup, shifting and merging, and is held in the result register,
//   which drives o_result and o_strobe.
//   Throughput: one token per cycle, set by that single registered stage.
//   Reset (synchronous, active low) clears both valid flags; tokens in
//   flight are dropped and o_strobe stays low until new tokens arrive.
module deflate_fixed_huffman_token_encoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fhte_pkg::t_token  i_token,
    output logic              o_strobe,
    output fhte_pkg::t_result o_result
);
    import fhte_pkg::*;

    logic      r_in_vld;
    t_token    r_tok;
    logic      r_out_vld;
    t_result   r_res;
    t_result   n_res;
    t_len_sym  len_sym;
    t_dist_sym dist_sym;

    assign busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_tok <= i_token;
        end
    end

    fhte_len_map u_len_map (
        .i_length (r_tok.match_length),
        .o_sym    (len_sym)
    );

    fhte_dist_map u_dist_map (
        .i_distance (r_tok.match_distance),
        .o_sym      (dist_sym)
    );

    // Build the bit string for the token
    always_comb begin
        t_code      lc;
        logic [4:0] pos_extra;
        logic [4:0] pos_dcode;
        logic [4:0] pos_dextra;
        lc         = litlen_wire({1'b0, r_tok.literal_byte});
        pos_extra  = {1'b0, len_sym.code.len};
        pos_dcode  = pos_extra + {2'd0, len_sym.extra_cnt};
        pos_dextra = pos_dcode + 5'd5;
        n_res      = '0;
        case (r_tok.opcode)
            OP_HEADER: begin
                n_res.code_bits = {28'd0, 1'b0, 1'b1, r_tok.final_block};
                n_res.bit_count = {1'b0, HDR_BITS};
            end
            OP_LITERAL: begin
                n_res.code_bits = {22'd0, lc.bits};
                n_res.bit_count = {1'b0, lc.len};
            end
            OP_MATCH: begin
                n_res.code_bits = {22'd0, len_sym.code.bits}
                                | ({26'd0, len_sym.extra_val} << pos_extra)
                                | ({26'd0, dist_sym.bits} << pos_dcode)
                                | ({18'd0, dist_sym.extra_val} << pos_dextra);
                n_res.bit_count = pos_dextra + {1'b0, dist_sym.extra_cnt};
            end
            default: begin
                // End of block: seven zero bits
                lc              = litlen_wire(SYM_EOB);
                n_res.code_bits = {22'd0, lc.bits};
                n_res.bit_count = {1'b0, lc.len};
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_res;

    // Every accepted token gives a result through the input and result registers
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("accepted word produced no result");

    // No result without a token accepted through the input and result registers
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    // Every result carries at least three bits
    a_min_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.bit_count >= 5'd3))
        else $error("bit count below three");

    // Nothing is set beyond the stated bit count
    a_clean_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.code_bits >> o_result.bit_count) == 31'd0))
        else $error("bits set beyond bit count");

endmodule

### rtl/core/fhte_len_map.sv
// Maps a match length to its length symbol code and extra bits.
// Depends on fhte_pkg.
module fhte_len_map (
    input  logic [8:0]        i_length,
    output fhte_pkg::t_len_sym o_sym
);
    import fhte_pkg::*;

    logic [8:0] clamped;
    logic [7:0] v;
    logic [4:0] idx;

    // Clamp to 3..258 and rebase so that length 3 is zero
    always_comb begin
        if (i_length < 9'd3) begin
            clamped = 9'd3;
        end else if (i_length > 9'd258) begin
            clamped = 9'd258;
        end else begin
            clamped = i_length;
        end
    end
    assign v = 8'(clamped - 9'd3);

    // Range lookup from the leading one of the rebased length
    always_comb begin
        idx             = {2'd0, v[2:0]};
        o_sym.extra_cnt = 3'd0;
        o_sym.extra_val = 5'd0;
        if (v == 8'd255) begin
            idx = 5'd28;
        end else if (v[7]) begin
            idx             = 5'd24 + {3'd0, v[6:5]};
            o_sym.extra_cnt = 3'd5;
            o_sym.extra_val = v[4:0];
        end else if (v[6]) begin
            idx             = 5'd20 + {3'd0, v[5:4]};
            o_sym.extra_cnt = 3'd4;
            o_sym.extra_val = {1'b0, v[3:0]};
        end else if (v[5]) begin
            idx             = 5'd16 + {3'd0, v[4:3]};
            o_sym.extra_cnt = 3'd3;
            o_sym.extra_val = {2'd0, v[2:0]};
        end else if (v[4]) begin
            idx             = 5'd12 + {3'd0, v[3:2]};
            o_sym.extra_cnt = 3'd2;
            o_sym.extra_val = {3'd0, v[1:0]};
        end else if (v[3]) begin
            idx             = 5'd8 + {3'd0, v[2:1]};
            o_sym.extra_cnt = 3'd1;
            o_sym.extra_val = {4'd0, v[0]};
        end
        o_sym.code = litlen_wire(SYM_LEN_FIRST + {4'd0, idx});
    end

endmodule

### rtl/core/fhte_dist_map.sv
// Maps a match distance to its 5-bit distance code and extra bits.
// Depends on fhte_pkg.
module fhte_dist_map (
    input  logic [15:0]         i_distance,
    output fhte_pkg::t_dist_sym o_sym
);
    import fhte_pkg::*;

    logic [14:0] w;
    logic [4:0]  idx;

    // Clamp to 1..32768 and rebase so that distance 1 is zero
    always_comb begin
        if (i_distance == 16'd0) begin
            w = 15'd0;
        end else if (i_distance > 16'd32768) begin
            w = 15'h7FFF;
        end else begin
            w = 15'(i_distance - 16'd1);
        end
    end

    // Range lookup: the highest set bit picks the symbol pair, the bit
    // below it picks the member, the rest are the extra bits
    always_comb begin
        idx             = {3'd0, w[1:0]};
        o_sym.extra_cnt = 4'd0;
        o_sym.extra_val = 13'd0;
        for (int p = 2; p < 15; p++) begin
            if (w[p]) begin
                idx             = 5'(2 * p) + {4'd0, w[p - 1]};
                o_sym.extra_cnt = 4'(p - 1);
                o_sym.extra_val = w[12:0] & 13'((1 << (p - 1)) - 1);
            end
        end
        // Distance code goes most significant bit first
        for (int i = 0; i < 5; i++) begin
            o_sym.bits[i] = idx[4 - i];
        end
    end

endmodule
